// ===== rtl/core/ple_pkg.sv =====
package ple_pkg;

	localparam int CAPACITY_DEF = 16;
	localparam int DATA_W       = 32;
	localparam int POS_W        = 8;
	localparam int COUNT_OUT_W  = 5;

	typedef enum logic [2:0] {
		MODE_INS_FRONT  = 3'd0,
		MODE_INS_BACK   = 3'd1,
		MODE_INS_AT     = 3'd2,
		MODE_DEL_FRONT  = 3'd3,
		MODE_DEL_BACK   = 3'd4,
		MODE_DEL_CENTRE = 3'd5,
		MODE_DEL_AT     = 3'd6,
		MODE_READ_ALL   = 3'd7
	} ple_mode_t;

	typedef enum logic [2:0] {
		STAT_OK      = 3'd0,
		STAT_INVALID = 3'd1,
		STAT_RANGE   = 3'd2,
		STAT_EMPTY   = 3'd3,
		STAT_SHORT   = 3'd4,
		STAT_FULL    = 3'd5
	} ple_status_t;

	typedef enum logic [1:0] {
		CELL_HOLD = 2'd0,
		CELL_INS  = 2'd1,
		CELL_DEL  = 2'd2,
		CELL_ROT  = 2'd3
	} ple_cell_op_t;

	typedef struct packed {
		ple_mode_t                  mode;
		logic [POS_W-1:0]           position;
		logic signed [DATA_W-1:0]   value;
	} ple_req_t;

	typedef struct packed {
		ple_status_t                status;
		logic signed [DATA_W-1:0]   entry_value;
		logic                       is_last;
		logic [COUNT_OUT_W-1:0]     entry_count;
	} ple_rsp_t;

endpackage

// ===== rtl/core/ple_cell.sv =====
module ple_cell import ple_pkg::*; #(
	parameter int CAPACITY = CAPACITY_DEF,
	parameter int INDEX    = 0
) (
	input  logic                                  clk,
	input  ple_cell_op_t                          op,
	input  logic [$clog2(CAPACITY)-1:0]           idx,
	input  logic [$clog2(CAPACITY)-1:0]           last,
	input  logic signed [DATA_W-1:0]              value,
	input  logic signed [DATA_W-1:0]              prev_data,
	input  logic signed [DATA_W-1:0]              next_data,
	input  logic signed [DATA_W-1:0]              head_data,
	output logic signed [DATA_W-1:0]              data
);

	localparam int IW = $clog2(CAPACITY);
	localparam logic [IW-1:0] MY_IDX = IW'(INDEX);

	logic signed [DATA_W-1:0] data_q;
	logic signed [DATA_W-1:0] data_d;

	always_comb begin
		data_d = data_q;
		case (op)
			CELL_INS: begin
				if (MY_IDX == idx) begin
					data_d = value;
				end else if (MY_IDX > idx) begin
					data_d = prev_data;
				end
			end
			CELL_DEL: begin
				if (MY_IDX >= idx) begin
					data_d = next_data;
				end
			end
			CELL_ROT: begin
				if (MY_IDX == last) begin
					data_d = head_data;
				end else if (MY_IDX < last) begin
					data_d = next_data;
				end
			end
			default: begin
				data_d = data_q;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		data_q <= data_d;
	end

	assign data = data_q;

endmodule

// ===== rtl/core/positional_list_engine_unit.sv =====
// Each request other than read_all yields one result, presented in the cycle after acceptance;
// such requests are accepted back to back, one per cycle, while the output slot drains.
// read_all holds the request channel from acceptance until its last entry is loaded:
// the cell chain rotates by one place per emitted entry, the first entry is registered from
// cell 0 in the read state and the rest follow at one per cycle while the output slot drains.
// Reset clears the entry count, the sequencer and the output valid; cells are undefined.
module positional_list_engine_unit import ple_pkg::*; #(
	parameter int CAPACITY = CAPACITY_DEF
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     req_valid,
	output logic     req_stall,
	input  ple_req_t req,
	output logic     rsp_valid,
	input  logic     rsp_stall,
	output ple_rsp_t rsp
);

	localparam int IW  = $clog2(CAPACITY);
	localparam int CW  = $clog2(CAPACITY + 1);
	localparam int PW  = POS_W + 1;
	localparam logic [CW-1:0] FULL_CNT = CW'(CAPACITY);

	typedef enum logic [1:0] {
		S_IDLE = 2'b01,
		S_READ = 2'b10
	} ple_state_t;

	ple_state_t state_q;
	logic [CW-1:0] count_q;
	logic [CW-1:0] count_d;
	logic [IW-1:0] rd_q;
	logic rsp_valid_q;
	ple_rsp_t rsp_q;

	ple_cell_op_t cell_op;
	logic [IW-1:0] cell_idx;
	logic [IW-1:0] cell_last;
	logic signed [DATA_W-1:0] cell_data [CAPACITY];

	logic accept;
	logic slot_free;
	logic load;
	logic start_read;
	ple_rsp_t rsp_d;
	ple_status_t st;
	logic [PW-1:0] pos_ext;
	logic [PW-1:0] cnt_ext;
	logic rd_last;

	assign slot_free = !rsp_valid_q || !rsp_stall;
	assign req_stall = (state_q == S_READ) || !slot_free;
	assign accept    = req_valid && !req_stall;
	assign pos_ext   = PW'(req.position);
	assign cnt_ext   = PW'(count_q);
	assign rd_last   = (rd_q == cell_last);

	always_comb begin
		cell_op    = CELL_HOLD;
		cell_idx   = '0;
		cell_last  = IW'(count_q - CW'(1));
		count_d    = count_q;
		load       = 1'b0;
		start_read = 1'b0;
		st         = STAT_OK;
		rsp_d      = rsp_q;
		if (state_q == S_READ) begin
			if (slot_free) begin
				cell_op = CELL_ROT;
				load    = 1'b1;
				rsp_d.status      = STAT_OK;
				rsp_d.entry_value = cell_data[0];
				rsp_d.is_last     = rd_last;
				rsp_d.entry_count = COUNT_OUT_W'(count_q);
			end
		end else if (accept) begin
			case (req.mode)
				MODE_INS_FRONT: begin
					if (count_q == FULL_CNT) begin
						st = STAT_FULL;
					end else begin
						cell_op  = CELL_INS;
						cell_idx = '0;
					end
				end
				MODE_INS_BACK: begin
					if (count_q == FULL_CNT) begin
						st = STAT_FULL;
					end else begin
						cell_op  = CELL_INS;
						cell_idx = IW'(count_q);
					end
				end
				MODE_INS_AT: begin
					if (req.position == '0) begin
						st = STAT_INVALID;
					end else if (pos_ext > cnt_ext + PW'(1)) begin
						st = STAT_RANGE;
					end else if (count_q == FULL_CNT) begin
						st = STAT_FULL;
					end else begin
						cell_op  = CELL_INS;
						cell_idx = IW'(req.position - POS_W'(1));
					end
				end
				MODE_DEL_FRONT: begin
					if (count_q == '0) begin
						st = STAT_EMPTY;
					end else begin
						cell_op  = CELL_DEL;
						cell_idx = '0;
					end
				end
				MODE_DEL_BACK: begin
					if (count_q == '0) begin
						st = STAT_EMPTY;
					end else begin
						cell_op  = CELL_DEL;
						cell_idx = IW'(count_q - CW'(1));
					end
				end
				MODE_DEL_CENTRE: begin
					if (count_q < CW'(2)) begin
						st = STAT_SHORT;
					end else begin
						cell_op  = CELL_DEL;
						cell_idx = IW'(count_q >> 1);
					end
				end
				MODE_DEL_AT: begin
					if (count_q == '0 || req.position == '0 || pos_ext > cnt_ext) begin
						st = STAT_INVALID;
					end else begin
						cell_op  = CELL_DEL;
						cell_idx = IW'(req.position - POS_W'(1));
					end
				end
				MODE_READ_ALL: begin
					if (count_q == '0) begin
						st = STAT_EMPTY;
					end else begin
						start_read = 1'b1;
					end
				end
				default: begin
					st = STAT_INVALID;
				end
			endcase
			if (cell_op == CELL_INS) begin
				count_d = count_q + CW'(1);
			end else if (cell_op == CELL_DEL) begin
				count_d = count_q - CW'(1);
			end
			if (!start_read) begin
				load = 1'b1;
				rsp_d.status      = st;
				rsp_d.entry_value = '0;
				rsp_d.is_last     = 1'b1;
				rsp_d.entry_count = COUNT_OUT_W'(count_d);
			end
		end
	end

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic signed [DATA_W-1:0] prev_w;
		logic signed [DATA_W-1:0] next_w;
		if (i == 0) begin : g_first
			assign prev_w = req.value;
		end else begin : g_mid_prev
			assign prev_w = cell_data[i-1];
		end
		if (i == CAPACITY - 1) begin : g_end
			assign next_w = cell_data[i];
		end else begin : g_mid_next
			assign next_w = cell_data[i+1];
		end
		ple_cell #(
			.CAPACITY (CAPACITY),
			.INDEX    (i)
		) u_cell (
			.clk       (clk),
			.op        (cell_op),
			.idx       (cell_idx),
			.last      (cell_last),
			.value     (req.value),
			.prev_data (prev_w),
			.next_data (next_w),
			.head_data (cell_data[0]),
			.data      (cell_data[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			rd_q        <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			count_q <= count_d;
			if (load) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (start_read) begin
						state_q <= S_READ;
						rd_q    <= '0;
					end
				end
				S_READ: begin
					if (slot_free) begin
						rd_q <= rd_q + IW'(1);
						if (rd_last) begin
							state_q <= S_IDLE;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			rsp_q <= rsp_d;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

// ===== tb/positional_list_engine_unit_test.sv =====
`timescale 1ns / 100ps

module positional_list_engine_unit_test;
	import ple_pkg::*;

	localparam int CYCLE_LIMIT  = 300000;
	localparam int RANDOM_ITEMS = 400;
	localparam int BLOCK_ITEMS  = 25;

	typedef struct packed {
		ple_mode_t              mode;
		logic [POS_W-1:0]       position;
		logic [DATA_W-1:0]      value;
		logic                   typed;
		ple_status_t            status;
		logic [COUNT_OUT_W-1:0] count;
	} drill_t;

	logic     clk;
	logic     arst_n;
	logic     req_valid;
	logic     req_stall;
	ple_req_t req;
	logic     rsp_valid;
	logic     rsp_stall = 1'b0;
	ple_rsp_t rsp;

	ple_rsp_t                 pending_rsp[$];
	logic signed [DATA_W-1:0] list_cells [CAPACITY_DEF];
	int unsigned              list_fill;

	int  errors = 0;
	int  cycles = 0;
	int  stall_left = 0;
	bit  calm;
	int  requests_sent;
	int  reads_sent;
	int  results_checked = 0;
	int  full_refusals = 0;

	ple_mode_t grow_ops [3] = '{MODE_INS_FRONT, MODE_INS_BACK, MODE_INS_AT};
	ple_mode_t shrink_ops [4] = '{MODE_DEL_FRONT, MODE_DEL_BACK, MODE_DEL_CENTRE, MODE_DEL_AT};
	logic [DATA_W-1:0] edge_values [4] = '{32'h8000_0000, 32'h7fff_ffff, 32'h0, 32'hffff_ffff};

	drill_t drills [26] = '{
		'{MODE_READ_ALL,   8'd0,   32'h0,         1'b1, STAT_EMPTY,   5'd0},
		'{MODE_DEL_FRONT,  8'd0,   32'h0,         1'b1, STAT_EMPTY,   5'd0},
		'{MODE_DEL_BACK,   8'd0,   32'h0,         1'b1, STAT_EMPTY,   5'd0},
		'{MODE_DEL_CENTRE, 8'd0,   32'h0,         1'b1, STAT_SHORT,   5'd0},
		'{MODE_DEL_AT,     8'd1,   32'h0,         1'b1, STAT_INVALID, 5'd0},
		'{MODE_INS_AT,     8'd0,   32'h5,         1'b1, STAT_INVALID, 5'd0},
		'{MODE_INS_AT,     8'd2,   32'h5,         1'b1, STAT_RANGE,   5'd0},
		'{MODE_INS_FRONT,  8'd0,   32'h7fff_ffff, 1'b1, STAT_OK,      5'd1},
		'{MODE_DEL_CENTRE, 8'd0,   32'h0,         1'b1, STAT_SHORT,   5'd1},
		'{MODE_READ_ALL,   8'd0,   32'h0,         1'b0, STAT_OK,      5'd0},
		'{MODE_INS_BACK,   8'd0,   32'h8000_0000, 1'b1, STAT_OK,      5'd2},
		'{MODE_INS_AT,     8'd2,   32'hffff_ffff, 1'b1, STAT_OK,      5'd3},
		'{MODE_INS_AT,     8'd4,   32'h0,         1'b1, STAT_OK,      5'd4},
		'{MODE_INS_AT,     8'd1,   32'h1234_5678, 1'b1, STAT_OK,      5'd5},
		'{MODE_READ_ALL,   8'd0,   32'h0,         1'b0, STAT_OK,      5'd0},
		'{MODE_DEL_AT,     8'd0,   32'h0,         1'b1, STAT_INVALID, 5'd5},
		'{MODE_DEL_AT,     8'd6,   32'h0,         1'b1, STAT_INVALID, 5'd5},
		'{MODE_INS_AT,     8'd255, 32'h0,         1'b1, STAT_RANGE,   5'd5},
		'{MODE_DEL_AT,     8'd255, 32'h0,         1'b1, STAT_INVALID, 5'd5},
		'{MODE_DEL_CENTRE, 8'd0,   32'h0,         1'b0, STAT_OK,      5'd0},
		'{MODE_DEL_AT,     8'd4,   32'h0,         1'b0, STAT_OK,      5'd0},
		'{MODE_DEL_FRONT,  8'd0,   32'h0,         1'b0, STAT_OK,      5'd0},
		'{MODE_DEL_BACK,   8'd0,   32'h0,         1'b0, STAT_OK,      5'd0},
		'{MODE_READ_ALL,   8'd0,   32'h0,         1'b0, STAT_OK,      5'd0},
		'{MODE_DEL_AT,     8'd1,   32'h0,         1'b1, STAT_OK,      5'd0},
		'{MODE_READ_ALL,   8'd0,   32'h0,         1'b1, STAT_EMPTY,   5'd0}
	};

	positional_list_engine_unit #(
		.CAPACITY(CAPACITY_DEF)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req(req),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp(rsp)
	);

	always #4 clk = ~clk;

	function automatic ple_rsp_t make_rsp(ple_status_t st, logic [DATA_W-1:0] v, logic last,
		int unsigned cnt);
		ple_rsp_t r;
		r.status      = st;
		r.entry_value = v;
		r.is_last     = last;
		r.entry_count = cnt[COUNT_OUT_W-1:0];
		return r;
	endfunction

	// Updates the list copy for one accepted request and, when asked, queues its results.
	task automatic apply_list_request(input ple_req_t r, input bit record);
		ple_status_t st;
		int unsigned idx;
		int unsigned i;
		bit          grow;
		bit          shrink;
		st     = STAT_OK;
		idx    = 0;
		grow   = 1'b0;
		shrink = 1'b0;
		case (r.mode)
			MODE_INS_FRONT, MODE_INS_BACK, MODE_INS_AT: begin
				if (r.mode == MODE_INS_AT && r.position == 0)
					st = STAT_INVALID;
				else if (r.mode == MODE_INS_AT && r.position > list_fill + 1)
					st = STAT_RANGE;
				else if (list_fill >= CAPACITY_DEF)
					st = STAT_FULL;
				else begin
					grow = 1'b1;
					if (r.mode == MODE_INS_BACK)
						idx = list_fill;
					else if (r.mode == MODE_INS_AT)
						idx = r.position - 1;
				end
			end
			MODE_DEL_FRONT, MODE_DEL_BACK: begin
				if (list_fill == 0)
					st = STAT_EMPTY;
				else begin
					shrink = 1'b1;
					idx = (r.mode == MODE_DEL_BACK) ? list_fill - 1 : 0;
				end
			end
			MODE_DEL_CENTRE: begin
				if (list_fill < 2)
					st = STAT_SHORT;
				else begin
					shrink = 1'b1;
					idx = list_fill / 2;
				end
			end
			MODE_DEL_AT: begin
				if (list_fill == 0 || r.position == 0 || r.position > list_fill)
					st = STAT_INVALID;
				else begin
					shrink = 1'b1;
					idx = r.position - 1;
				end
			end
			default: begin
				if (!record)
					return;
				if (list_fill == 0)
					pending_rsp.push_back(make_rsp(STAT_EMPTY, '0, 1'b1, 0));
				for (i = 0; i < list_fill; i++)
					pending_rsp.push_back(make_rsp(STAT_OK, list_cells[i], i + 1 == list_fill,
						list_fill));
				return;
			end
		endcase
		if (grow) begin
			for (i = list_fill; i > idx; i--)
				list_cells[i] = list_cells[i - 1];
			list_cells[idx] = r.value;
			list_fill++;
		end
		if (shrink) begin
			for (i = idx; i + 1 < list_fill; i++)
				list_cells[i] = list_cells[i + 1];
			list_fill--;
		end
		if (record)
			pending_rsp.push_back(make_rsp(st, '0, 1'b1, list_fill));
	endtask

	task automatic issue_request(input ple_req_t r, input bit record);
		int gap;
		gap = calm ? 0 : $urandom_range(0, 3);
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req       <= r;
		req_valid <= 1'b1;
		@(posedge clk);
		while (req_stall)
			@(posedge clk);
		requests_sent++;
		if (r.mode == MODE_READ_ALL)
			reads_sent++;
		apply_list_request(r, record);
	endtask

	function automatic ple_mode_t pick_mode(int bias);
		int roll;
		int grow_share;
		int shrink_share;
		roll = $urandom_range(0, 99);
		case (bias)
			0: begin
				grow_share   = 70;
				shrink_share = 20;
			end
			1: begin
				grow_share   = 20;
				shrink_share = 70;
			end
			default: begin
				grow_share   = 42;
				shrink_share = 42;
			end
		endcase
		if (roll < grow_share)
			return grow_ops[$urandom_range(0, 2)];
		if (roll < grow_share + shrink_share)
			return shrink_ops[$urandom_range(0, 3)];
		return MODE_READ_ALL;
	endfunction

	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	always @(posedge clk) begin
		ple_rsp_t want;
		if (arst_n && rsp_valid && !rsp_stall) begin
			results_checked++;
			if (rsp.status == STAT_FULL)
				full_refusals++;
			if (pending_rsp.size() == 0) begin
				$error("unexpected result: status %0d, entry_value %0d, entry_count %0d",
					rsp.status, rsp.entry_value, rsp.entry_count);
				errors++;
			end else begin
				want = pending_rsp.pop_front();
				if (rsp.status !== want.status) begin
					$error("status: expected %0d, got %0d", want.status, rsp.status);
					errors++;
				end
				if (rsp.entry_value !== want.entry_value) begin
					$error("entry_value: expected %0d, got %0d", want.entry_value,
						rsp.entry_value);
					errors++;
				end
				if (rsp.is_last !== want.is_last) begin
					$error("is_last: expected %0d, got %0d", want.is_last, rsp.is_last);
					errors++;
				end
				if (rsp.entry_count !== want.entry_count) begin
					$error("entry_count: expected %0d, got %0d", want.entry_count,
						rsp.entry_count);
					errors++;
				end
			end
			stall_left = calm ? 0 : $urandom_range(0, 3);
		end else if (stall_left > 0) begin
			stall_left--;
		end
		rsp_stall <= (stall_left != 0);
	end

	initial begin
		ple_req_t r;
		int       bias;
		int       n;
		clk             = 1'b0;
		arst_n          = 1'b0;
		req_valid       = 1'b0;
		req             = '0;
		calm            = 1'b0;
		requests_sent   = 0;
		reads_sent      = 0;
		list_fill       = 0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (drills[k]) begin
			r.mode     = drills[k].mode;
			r.position = drills[k].position;
			r.value    = drills[k].value;
			issue_request(r, !drills[k].typed);
			if (drills[k].typed)
				pending_rsp.push_back(make_rsp(drills[k].status, '0, 1'b1,
					32'(drills[k].count)));
		end

		for (n = 0; n < RANDOM_ITEMS; n++) begin
			if (n % BLOCK_ITEMS == 0) begin
				bias = $urandom_range(0, 2);
				calm = ($urandom_range(0, 3) == 0);
				// Hold the sender back until the block has drained completely.
				if (n % (4 * BLOCK_ITEMS) == 2 * BLOCK_ITEMS) begin
					req_valid <= 1'b0;
					while (pending_rsp.size() != 0)
						@(posedge clk);
				end
			end
			r.mode = pick_mode(bias);
			if ($urandom_range(0, 4) == 0)
				r.position = POS_W'($urandom_range(0, 255));
			else
				r.position = POS_W'($urandom_range(0, list_fill + 2));
			if ($urandom_range(0, 7) == 0)
				r.value = edge_values[$urandom_range(0, 3)];
			else
				r.value = $urandom();
			issue_request(r, 1'b1);
		end

		req_valid <= 1'b0;
		while (pending_rsp.size() != 0)
			@(posedge clk);
		repeat (40) @(posedge clk);

		$display("Covered %0d requests, %0d of them full list reads, and checked %0d results.",
			requests_sent, reads_sent, results_checked);
		$display("Inserts refused on a full list: %0d.", full_refusals);
		if (errors == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule

// ===== files.f =====
rtl/core/ple_pkg.sv
rtl/core/ple_cell.sv
rtl/core/positional_list_engine_unit.sv
tb/positional_list_engine_unit_test.sv
